FILE: src/oaar_pkg.sv
// ----------------------------------------------------------------------------
// oaar_pkg
// Shared types and constants for the overlap-add accumulator ring.
// ----------------------------------------------------------------------------
`default_nettype none

package oaar_pkg;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int OFFSET_W = 9;
    localparam int VALUE_W  = 48;
    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 5;
    localparam int SBITS_W  = 6;
    localparam int RLEN_W   = 10;

    localparam logic [FRAC_W-1:0]  FRAC_BITS_RST   = 5'd0;
    localparam logic [SBITS_W-1:0] SAMPLE_BITS_RST = 6'd16;
    localparam logic [RLEN_W-1:0]  RING_LEN_RST    = 10'd512;

    localparam logic [SBITS_W-1:0] SBITS_MIN = 6'd2;
    localparam logic [SBITS_W-1:0] SBITS_MAX = 6'd32;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_FRAC_BITS   = 2'd0;
    localparam logic [1:0] REG_SAMPLE_BITS = 2'd1;
    localparam logic [1:0] REG_RING_LEN    = 2'd2;

    localparam logic KIND_EMIT = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_PTR,
        ST_MOD_IDX,
        ST_RD,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

`default_nettype wire

FILE: src/oaar_mod.sv
// ----------------------------------------------------------------------------
// oaar_mod
// Bit-serial remainder unit: operand mod modulus, one operand bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oaar_mod #(
    parameter int OP_W  = 10,
    parameter int LEN_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [OP_W-1:0]    operand,
    input  wire logic [LEN_W-1:0]   modulus,
    output oaar_pkg::mod_stat_t     stat,
    output logic      [LEN_W-1:0]   rem
);

    import oaar_pkg::*;

    localparam int CNT_W = $clog2(OP_W + 1);

    logic [OP_W-1:0]  shift_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   mod_ext;
    logic [LEN_W-1:0] rem_next;

    always_comb
    begin
        trial   = {rem_reg, shift_reg[OP_W-1]};
        mod_ext = {1'b0, modulus};
        if (trial >= mod_ext)
        begin
            rem_next = LEN_W'(trial - mod_ext);
        end
        else
        begin
            rem_next = LEN_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            shift_reg <= operand;
            rem_reg   <= '0;
            cnt_reg   <= CNT_W'(OP_W);
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

`default_nettype wire

FILE: src/overlap_add_accumulator_ring_top.sv
// ----------------------------------------------------------------------------
// overlap_add_accumulator_ring_top
// Overlap-add ring of signed accumulators with rounded, saturated emit.
//
//   channel  dir  handshake              word
//   in       in   in_valid / in_ready    kind, offset, add_value
//   out      out  out_valid / out_ready  out_sample, sample_valid, overflow
//   cfg      in   APB, pready tied high  frac_bits, sample_bits, ring_len
//
// One word at a time. Emit runs one pass of the bit-serial modulo unit, add two,
// each over an operand of SUM_W = max(clog2(DEPTH), 9) + 1 bits.
// After reset a clearing pass zeroes the ring, with in_ready low.
// A new word is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_add_accumulator_ring_top #(
    parameter int DEPTH     = 512,
    parameter int ACC_WIDTH = 48
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               kind,
    input  wire logic        [oaar_pkg::OFFSET_W-1:0] offset,
    input  wire logic signed [oaar_pkg::VALUE_W-1:0]  add_value,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [oaar_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                    sample_valid,
    output logic                                    overflow,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [oaar_pkg::ADDR_W-1:0]   paddr,
    input  wire logic        [oaar_pkg::DATA_W-1:0]   pwdata,
    output logic             [oaar_pkg::DATA_W-1:0]   prdata,
    output logic                                    pready
);

    import oaar_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int LEN_W  = ($clog2(DEPTH + 1) > RLEN_W) ? $clog2(DEPTH + 1) : RLEN_W;
    localparam int SUM_W  = ((PTR_W > OFFSET_W) ? PTR_W : OFFSET_W) + 1;
    localparam int SA_W   = ((ACC_WIDTH > VALUE_W) ? ACC_WIDTH : VALUE_W) + 1;
    localparam int R_W    = ACC_WIDTH + 1;
    localparam int CMP_W  = (R_W > SAMPLE_W + 1) ? R_W : SAMPLE_W + 1;

    localparam logic signed [SA_W-1:0] ACC_MAX =
        $signed((SA_W'(1) << (ACC_WIDTH - 1)) - SA_W'(1));
    localparam logic signed [SA_W-1:0] ACC_MIN = ~ACC_MAX;

    // configuration
    logic [FRAC_W-1:0]  frac_bits_reg;
    logic [SBITS_W-1:0] sample_bits_reg;
    logic [RLEN_W-1:0]  ring_len_reg;
    logic               cfg_we;
    logic [LEN_W-1:0]   eff_len;

    // control
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   clr_cnt_reg;
    logic [PTR_W-1:0]   read_ptr_reg;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   idx_reg;
    logic               kind_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic signed [VALUE_W-1:0] add_value_reg;

    // modulo unit
    logic               mod_start;
    logic [SUM_W-1:0]   mod_operand;
    mod_stat_t          mod_stat;
    logic [LEN_W-1:0]   mod_rem;

    // memory
    logic [ACC_WIDTH-1:0] mem [DEPTH];
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    logic [ACC_WIDTH-1:0] mem_wdata;
    logic                 mem_re;
    logic signed [ACC_WIDTH-1:0] rd_data_reg;

    // datapath
    logic signed [SA_W-1:0]  add_sum;
    logic                    add_ovf;
    logic signed [ACC_WIDTH-1:0] shifted;
    logic signed [ACC_WIDTH-1:0] half_tap;
    logic [FRAC_W-1:0]       frac_m1;
    logic                    round_bit;
    logic signed [R_W-1:0]   rounded;
    logic signed [R_W-1:0]   round_reg;
    logic                    ovf_reg;
    logic [PTR_W:0]          rp_inc;
    logic [PTR_W-1:0]        rp_next;

    // saturation
    logic [SBITS_W-1:0]      nb;
    logic signed [CMP_W-1:0] sat_hi;
    logic signed [CMP_W-1:0] sat_lo;
    logic signed [CMP_W-1:0] r_ext;
    logic signed [CMP_W-1:0] sat_val;
    logic                    out_load;

    logic                    out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                    sample_valid_reg;
    logic                    overflow_reg;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_bits_reg   <= FRAC_BITS_RST;
            sample_bits_reg <= SAMPLE_BITS_RST;
            ring_len_reg    <= RING_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_FRAC_BITS:   frac_bits_reg   <= pwdata[FRAC_W-1:0];
                REG_SAMPLE_BITS: sample_bits_reg <= pwdata[SBITS_W-1:0];
                REG_RING_LEN:    ring_len_reg    <= pwdata[RLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAC_BITS:   prdata = DATA_W'(frac_bits_reg);
            REG_SAMPLE_BITS: prdata = DATA_W'(sample_bits_reg);
            REG_RING_LEN:    prdata = DATA_W'(ring_len_reg);
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        if (ring_len_reg == '0 || 32'(ring_len_reg) > DEPTH)
        begin
            eff_len = LEN_W'(DEPTH);
        end
        else
        begin
            eff_len = LEN_W'(ring_len_reg);
        end
    end

    // ---------------------------------------------------------- modulo unit
    oaar_mod #(
        .OP_W  (SUM_W),
        .LEN_W (LEN_W)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .operand (mod_operand),
        .modulus (eff_len),
        .stat    (mod_stat),
        .rem     (mod_rem)
    );

    // ------------------------------------------------------------- datapath
    always_comb
    begin
        add_sum = SA_W'(rd_data_reg) + SA_W'(add_value_reg);
        add_ovf = (add_sum > ACC_MAX) || (add_sum < ACC_MIN);

        frac_m1   = frac_bits_reg - FRAC_W'(1);
        shifted   = rd_data_reg >>> frac_bits_reg;
        half_tap  = rd_data_reg >>> frac_m1;
        round_bit = (frac_bits_reg != '0) && half_tap[0];
        rounded   = R_W'(shifted) + R_W'($signed({1'b0, round_bit}));

        rp_inc  = {1'b0, rp_reg} + (PTR_W + 1)'(1);
        rp_next = ((LEN_W + 1)'(rp_inc) == (LEN_W + 1)'(eff_len)) ? '0 : rp_inc[PTR_W-1:0];
    end

    always_comb
    begin
        if (sample_bits_reg < SBITS_MIN)
        begin
            nb = SBITS_MIN;
        end
        else if (sample_bits_reg > SBITS_MAX)
        begin
            nb = SBITS_MAX;
        end
        else
        begin
            nb = sample_bits_reg;
        end
        sat_hi = $signed((CMP_W'(1) << (nb - SBITS_W'(1))) - CMP_W'(1));
        sat_lo = ~sat_hi;
        r_ext  = CMP_W'(round_reg);
        if (r_ext > sat_hi)
        begin
            sat_val = sat_hi;
        end
        else if (r_ext < sat_lo)
        begin
            sat_val = sat_lo;
        end
        else
        begin
            sat_val = r_ext;
        end
    end

    // ------------------------------------------------------------------ FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        mod_start   = 1'b0;
        mod_operand = SUM_W'(read_ptr_reg);
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == PTR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD_PTR;
                end
            end
            ST_MOD_PTR:
            begin
                if (mod_stat.done)
                begin
                    if (kind_reg == KIND_ADD)
                    begin
                        mod_start   = 1'b1;
                        mod_operand = SUM_W'(mod_rem[PTR_W-1:0]) + SUM_W'(offset_reg);
                        state_next  = ST_MOD_IDX;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_MOD_IDX:
            begin
                if (mod_stat.done)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    mem_we    = !add_ovf;
                    mem_wdata = add_sum[ACC_WIDTH-1:0];
                end
                else
                begin
                    mem_we = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------- control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            read_ptr_reg <= '0;
            rp_reg       <= '0;
            idx_reg      <= '0;
            kind_reg     <= KIND_EMIT;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + PTR_W'(1);
            end
            if (in_valid && in_ready)
            begin
                kind_reg <= kind;
            end
            if (mod_stat.done && state_reg == ST_MOD_PTR)
            begin
                rp_reg  <= mod_rem[PTR_W-1:0];
                idx_reg <= mod_rem[PTR_W-1:0];
            end
            if (mod_stat.done && state_reg == ST_MOD_IDX)
            begin
                idx_reg <= mod_rem[PTR_W-1:0];
            end
            if (state_reg == ST_EXEC)
            begin
                read_ptr_reg <= (kind_reg == KIND_ADD) ? rp_reg : rp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            offset_reg    <= offset;
            add_value_reg <= add_value;
        end
        if (state_reg == ST_EXEC)
        begin
            round_reg <= (frac_bits_reg == '0) ? R_W'(rd_data_reg) : rounded;
            ovf_reg   <= (kind_reg == KIND_ADD) && add_ovf;
        end
    end

    // --------------------------------------------------------------- memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // --------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg   <= (kind_reg == KIND_ADD) ? '0 : sat_val[SAMPLE_W-1:0];
            sample_valid_reg <= (kind_reg == KIND_EMIT);
            overflow_reg     <= ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign sample_valid = sample_valid_reg;
    assign overflow     = overflow_reg;

    // ----------------------------------------------------------- assertions
    a_read_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(read_ptr_reg) < DEPTH)
        else $error("read pointer beyond ring depth");

    a_mem_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_EXEC))
        else $error("ring write outside clear or execute");

    a_mod_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> (state_reg == ST_MOD_PTR || state_reg == ST_MOD_IDX))
        else $error("modulo result arrived in wrong phase");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(sample_valid && overflow))
        else $error("emit word flagged overflow");

    a_add_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sample_valid) |-> (out_sample == '0))
        else $error("add word carries a nonzero sample");

endmodule

`default_nettype wire
